>>> design/id_tagged_slot_table_top_assert.svh
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Property macros shared by the slot table modules. Each macro samples on
// clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ID_TAGGED_SLOT_TABLE_TOP_ASSERT_SVH
`define ID_TAGGED_SLOT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ITS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot table assertion failed");
// Next-cycle implication.
`define ITS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot table assertion failed");
`else
`define ITS_ASSERT_IMPL(label, ante, cons)
`define ITS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/its_pkg.sv
// ----------------------------------------------------------------------------
// Slot table package
// Types and constants shared by the front queue, the slot cells and the
// back-end sequencer.
// ----------------------------------------------------------------------------
package its_pkg;

  localparam int unsigned OWNER_W = 16;
  localparam int unsigned GROUP_W = 32;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  // Request kinds as decoded by the front end.
  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_REMOVE = 2'd1,
    K_SELECT = 2'd2,
    K_CLEAR  = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_MATCH     = 3'd4,
    ST_NO_MATCH  = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EMIT
  } state_e;

  // One classified request as held in the queue.
  typedef struct packed {
    kind_e              kind;
    logic [OWNER_W-1:0] owner;
    logic [GROUP_W-1:0] group;
  } req_t;

  // Update commands for the slot cells.
  typedef struct packed {
    logic set;
    logic clr_one;
    logic clr_all;
  } cell_cmd_t;

  // One result transaction.
  typedef struct packed {
    status_e            status;
    logic [OWNER_W-1:0] requester;
    logic [OWNER_W-1:0] matched;
    logic               last;
  } result_t;

endpackage

>>> design/its_front.sv
// ----------------------------------------------------------------------------
// Slot table front end
// Accepts request transactions, decodes the request kind and holds them in a
// two-entry queue until the back end pops them.
// ----------------------------------------------------------------------------
`include "id_tagged_slot_table_top_assert.svh"

module its_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [its_pkg::TYPE_W-1:0]  in_type_i,
  input  logic [its_pkg::OWNER_W-1:0] in_owner_i,
  input  logic [its_pkg::GROUP_W-1:0] in_group_i,
  output logic                        q_valid_o,
  output its_pkg::req_t               q_head_o,
  input  logic                        pop_i
);
  import its_pkg::*;

  req_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] count_q;
  logic            push;
  req_t            req_in;

  // Decode the request kind.
  always_comb begin
    req_in.owner = in_owner_i;
    req_in.group = in_group_i;
    req_in.kind  = kind_e'(in_type_i);
  end

  assign in_ready_o = (count_q != Q_CW'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_head_o   = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ITS_ASSERT_IMPL(a_pop_not_empty, pop_i, count_q != '0)
  `ITS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= Q_CW'(Q_DEPTH))
  `ITS_ASSERT_NEXT(a_push_counts, push && !pop_i, count_q != '0)

endmodule

>>> design/its_cells.sv
// ----------------------------------------------------------------------------
// Slot table cells
// One cell per slot with its valid bit, owner and group, each comparing its
// own contents against the current request in parallel.
// ----------------------------------------------------------------------------
`include "id_tagged_slot_table_top_assert.svh"

module its_cells #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [its_pkg::OWNER_W-1:0] cmp_owner_i,
  input  logic [its_pkg::GROUP_W-1:0] cmp_group_i,
  input  its_pkg::cell_cmd_t          cmd_i,
  input  logic [SLOTS-1:0]            sel_i,
  output logic [SLOTS-1:0]            free_vec_o,
  output logic [SLOTS-1:0]            own_vec_o,
  output logic [SLOTS-1:0]            grp_vec_o,
  output logic [its_pkg::OWNER_W-1:0] sel_owner_o
);
  import its_pkg::*;

  logic [SLOTS-1:0]   valid_q;
  logic [OWNER_W-1:0] owner_q [SLOTS];
  logic [GROUP_W-1:0] group_q [SLOTS];

  // Per-cell compares.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec_o[i] = !valid_q[i];
      own_vec_o[i]  = valid_q[i] && (owner_q[i] == cmp_owner_i);
      grp_vec_o[i]  = valid_q[i] && (group_q[i] == cmp_group_i);
    end
  end

  // Owner of the selected cell through a one-hot AND-OR.
  always_comb begin
    sel_owner_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_owner_o = sel_owner_o | ({OWNER_W{sel_i[i]}} & owner_q[i]);
    end
  end

  // Cell contents are written on insert.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd_i.set && sel_i[i]) begin
        owner_q[i] <= cmp_owner_i;
        group_q[i] <= cmp_group_i;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr_all) begin
      valid_q <= '0;
    end else if (cmd_i.set) begin
      valid_q <= valid_q | sel_i;
    end else if (cmd_i.clr_one) begin
      valid_q <= valid_q & ~sel_i;
    end
  end

  `ITS_ASSERT_IMPL(a_sel_onehot, cmd_i.set || cmd_i.clr_one, $onehot(sel_i))
  `ITS_ASSERT_IMPL(a_set_free, cmd_i.set, (sel_i & valid_q) == '0)
  `ITS_ASSERT_NEXT(a_clr_all_empty, cmd_i.clr_all, valid_q == '0)

endmodule

>>> design/its_back.sv
// ----------------------------------------------------------------------------
// Slot table back end
// Pops requests from the queue, registers the cell match vector, then walks
// it lowest slot first, updating the cells and issuing result transactions
// through an output register.
// ----------------------------------------------------------------------------
`include "id_tagged_slot_table_top_assert.svh"

module its_back #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  its_pkg::req_t               q_head_i,
  output logic                        pop_o,
  output its_pkg::req_t               cur_o,
  output its_pkg::cell_cmd_t          cmd_o,
  output logic [SLOTS-1:0]            sel_o,
  input  logic [SLOTS-1:0]            free_vec_i,
  input  logic [SLOTS-1:0]            own_vec_i,
  input  logic [SLOTS-1:0]            grp_vec_i,
  input  logic [its_pkg::OWNER_W-1:0] sel_owner_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output its_pkg::result_t            out_o
);
  import its_pkg::*;

  state_e           state_q, state_d;
  req_t             cur_q, cur_d;
  logic [SLOTS-1:0] vec_q, vec_d;
  logic [SLOTS-1:0] lowbit, rest;
  logic             has;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, res;
  logic             out_free, emit, done;

  // Lowest pending slot of the registered match vector.
  assign lowbit   = vec_q & (~vec_q + {{(SLOTS-1){1'b0}}, 1'b1});
  assign rest     = vec_q & ~lowbit;
  assign has      = |vec_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign sel_o       = lowbit;
  assign cur_o       = cur_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Next state, cell commands and result.
  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    vec_d         = vec_q;
    pop_o         = 1'b0;
    emit          = 1'b0;
    done          = 1'b0;
    cmd_o         = '0;
    res.status    = ST_CLEARED;
    res.requester = cur_q.owner;
    res.matched   = '0;
    res.last      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = q_head_i;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        case (cur_q.kind)
          K_INSERT: vec_d = free_vec_i;
          K_REMOVE: vec_d = own_vec_i;
          K_SELECT: vec_d = grp_vec_i;
          default:  vec_d = '0;
        endcase
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          case (cur_q.kind)
            K_INSERT: begin
              res.status = has ? ST_INSERTED : ST_FULL;
              cmd_o.set  = has;
              done       = 1'b1;
            end
            K_REMOVE: begin
              res.status    = has ? ST_REMOVED : ST_NOT_FOUND;
              cmd_o.clr_one = has;
              done          = 1'b1;
            end
            K_SELECT: begin
              if (has) begin
                res.status  = ST_MATCH;
                res.matched = sel_owner_i;
                res.last    = ~|rest;
                vec_d       = rest;
                done        = ~|rest;
              end else begin
                res.status = ST_NO_MATCH;
                done       = 1'b1;
              end
            end
            default: begin
              res.status    = ST_CLEARED;
              cmd_o.clr_all = 1'b1;
              done          = 1'b1;
            end
          endcase
          // Chain straight into the next queued request.
          if (done) begin
            if (q_valid_i) begin
              pop_o   = 1'b1;
              cur_d   = q_head_i;
              state_d = S_CMP;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    vec_q <= vec_d;
    if (emit) begin
      out_q <= res;
    end
  end

  `ITS_ASSERT_NEXT(a_last_leaves_emit, emit && res.last, state_q != S_EMIT)
  `ITS_ASSERT_IMPL(a_pop_when_free, pop_o, (state_q == S_IDLE) || done)
  `ITS_ASSERT_IMPL(a_set_on_insert, cmd_o.set, (state_q == S_EMIT) && (cur_q.kind == K_INSERT))
  `ITS_ASSERT_IMPL(a_emit_has_room, emit, out_free)

endmodule

>>> design/id_tagged_slot_table_top.sv
// ----------------------------------------------------------------------------
// Slot table top level
// Request channel in, result channel out; a slot table keyed by owner and
// group with insert, remove, select-by-group and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis group: tuser carries the request kind
//   (0 insert, 1 remove, 2 select, 3 clear), tdata the owner and group ids.
//   Results leave on the m_axis group, one transaction per result; tlast
//   marks the final result of a request. A select returns one transaction
//   per matching slot in ascending slot order, or a single no-match result.
//   A request passes through the queue, the compare state, which registers
//   the match vector, and the result state, which loads the output register.
//   Each request takes a compare step over all slot cells in parallel and a
//   result step; a select walks the registered match vector and issues one
//   result per cycle while the receiver is ready.
//   A two-entry request queue sits in front, so up to two requests are
//   taken while results are pending. When the receiver stalls, the output
//   register holds its transaction, the walk pauses and the queue fills.
//   Reset empties the table, the queue and the output register.
// ----------------------------------------------------------------------------
module id_tagged_slot_table_top #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // owner_id[15:0], group_id[47:16]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[2:0], requester_id[18:3],
                                     // matched_owner[34:19], zero[39:35]
  output logic        m_axis_tlast
);
  import its_pkg::*;

  logic             q_valid, pop;
  req_t             q_head, cur;
  cell_cmd_t        cmd;
  logic [TABLE_SLOTS-1:0] sel, free_vec, own_vec, grp_vec;
  logic [OWNER_W-1:0]     sel_owner;
  result_t          res;

  // Request front end.
  its_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_type_i  (s_axis_tuser),
    .in_owner_i (s_axis_tdata[15:0]),
    .in_group_i (s_axis_tdata[47:16]),
    .q_valid_o  (q_valid),
    .q_head_o   (q_head),
    .pop_i      (pop)
  );

  // Slot cells.
  its_cells #(.SLOTS(TABLE_SLOTS)) u_cells (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmp_owner_i (cur.owner),
    .cmp_group_i (cur.group),
    .cmd_i       (cmd),
    .sel_i       (sel),
    .free_vec_o  (free_vec),
    .own_vec_o   (own_vec),
    .grp_vec_o   (grp_vec),
    .sel_owner_o (sel_owner)
  );

  // Back-end sequencer.
  its_back #(.SLOTS(TABLE_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .cur_o       (cur),
    .cmd_o       (cmd),
    .sel_o       (sel),
    .free_vec_i  (free_vec),
    .own_vec_i   (own_vec),
    .grp_vec_i   (grp_vec),
    .sel_owner_i (sel_owner),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack the result transaction.
  assign m_axis_tdata = {5'b0, res.matched, res.requester, res.status};
  assign m_axis_tlast = res.last;

endmodule
